### hw/rtl/ffrmc_pkg.sv
`default_nettype none
package ffrmc_pkg;

	// port widths
	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 104;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// serial unit sizes
	localparam int DIV_W  = 56;   // dividend / quotient bits
	localparam int DIVR_W = 18;   // divisor bits
	localparam int MC_W   = 60;   // multiplicand / product bits
	localparam int MP_W   = 25;   // multiplier bits, one per cycle

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IN_RATE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FREEZE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCK = 3'd4;

	// loop constants
	localparam logic [24:0] Q24_ONE   = 25'h1000000;
	localparam logic [31:0] LOCK_TIME = 32'd167772160;   // 10 s in Q8.24
	localparam logic [32:0] RATIO_MAX = 33'h1FFFFFFFF;
	localparam logic [DIVR_W-1:0] KP_ACQ  = 18'd200;
	localparam logic [DIVR_W-1:0] KP_LOCK = 18'd1000;
	localparam logic [DIVR_W-1:0] KI_ACQ  = 18'd20000;
	localparam logic [DIVR_W-1:0] KI_LOCK = 18'd100000;

	typedef enum logic [1:0] {
		MODE_PRIMING   = 2'd0,
		MODE_ACQUIRING = 2'd1,
		MODE_LOCKED    = 2'd2
	} loop_mode_t;

	typedef enum logic [2:0] {
		STAT_INACTIVE  = 3'd0,
		STAT_PRIMING   = 3'd1,
		STAT_RUNNING   = 3'd2,
		STAT_UNDERRUN  = 3'd3,
		STAT_OVERALLOC = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_PRE,
		SQ_BT,
		SQ_LPF,
		SQ_ERR,
		SQ_KI,
		SQ_KP,
		SQ_SLEW,
		SQ_RMUL,
		SQ_RDIV,
		SQ_NEED,
		SQ_FIN,
		SQ_WB
	} seq_state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic            start;
		logic [MC_W-1:0] mcand;
		logic [MP_W-1:0] mplier;
	} mul_req_t;

	typedef struct packed {
		logic            done;
		logic [MC_W-1:0] product;
	} mul_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/ffrmc_div.sv
`default_nettype none
module ffrmc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  ffrmc_pkg::div_req_t req,
	output ffrmc_pkg::div_rsp_t rsp
);
	import ffrmc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVR_W-1:0] dvsr_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIV_W-1:0]  dvd_q;   // dividend bits out at the top, quotient bits in at the bottom

	logic [DIVR_W:0]   part;
	logic [DIVR_W+1:0] trial;
	logic              ge;

	always_comb begin
		part  = {rem_q, dvd_q[DIV_W-1]};
		trial = {1'b0, part} - {2'b00, dvsr_q};
		ge    = !trial[DIVR_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvsr_q <= req.divisor;
			rem_q  <= '0;
			dvd_q  <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DIVR_W-1:0] : part[DIVR_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule
`default_nettype wire

### hw/rtl/ffrmc_mul.sv
`default_nettype none
module ffrmc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  ffrmc_pkg::mul_req_t req,
	output ffrmc_pkg::mul_rsp_t rsp
);
	import ffrmc_pkg::*;

	localparam int CNT_W = $clog2(MP_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MC_W-1:0]  acc_q;
	logic [MC_W-1:0]  mc_q;
	logic [MP_W-1:0]  mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MP_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// high bits lost off mc_q only ever meet zero multiplier bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mc_q  <= req.mcand;
			mp_q  <= req.mplier;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[MC_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[MP_W-1:1]};
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule
`default_nettype wire

### hw/rtl/fifo_fill_rate_matching_controller.sv
// FIFO fill rate matching controller.
// One input item per audio block on s_*: block length, FIFO fill, stream reset request and
// capture running flag. One result item per input on m_*: status, loop mode, drain count,
// ratio correction (Q40), resample ratio (Q28) and input samples to read.
// Registers are written through cfg_we / cfg_idx / cfg_data while the block is idle; the
// user must keep to this, as the block does not enforce it. An inactive or priming block
// goes from SQ_PRE straight to SQ_WB. A running block goes through five divisions on a
// bit-serial divider and up to three products on a bit-serial multiplier, the ratio product
// being skipped while the ratio is frozen. One item is in work at a time; s_tready is high
// only while no item is in work.
// The result sits in an output register: the next item is taken while it waits, and the
// loop holds its final write-back while that register is full and m_tready is low.
// Reset: registers return to their defaults, the loop to priming with the filtered fill at
// the target, and a stream reset is pending, so the first active block reports the fill as
// drain count.
`default_nettype none
module fifo_fill_rate_matching_controller #(
	parameter int unsigned FIFO_DEPTH  = 8192,
	parameter int unsigned READ_MARGIN = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ffrmc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [ffrmc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// block_samples[12:0], fill_level[26:13], reset_request[27], capture_running[28]
	input  logic [ffrmc_pkg::S_DATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status[2:0], loop_mode[4:3], drain_count[18:5], correction_q40[52:19],
	// ratio_q28[85:53], samples_to_read[99:86]
	output logic [ffrmc_pkg::M_DATA_W-1:0]      m_tdata
);
	import ffrmc_pkg::*;

	localparam logic [13:0] DEPTH_CAP = 14'((FIFO_DEPTH > 16383) ? 16383 : FIFO_DEPTH);
	localparam logic [19:0] MARGIN    = 20'(READ_MARGIN);
	localparam logic signed [42:0] ILIM = 43'sd1099511628;
	localparam logic signed [49:0] CLIM = 50'sd5497558139;
	localparam logic signed [34:0] SLIM = 35'sd27487791;

	// configuration
	logic [17:0] in_rate_q, out_rate_q;
	logic [13:0] target_q;
	logic        freeze_q;
	logic [12:0] max_block_q;

	// loop state
	loop_mode_t         mode_q;
	logic               pending_q;
	logic [29:0]        ff_q;
	logic signed [31:0] integ_q;
	logic signed [33:0] prev_q;
	logic [31:0]        at_q;

	// item and working registers
	logic [12:0]        bs_q;
	logic [13:0]        fill_q;
	logic               cap_q;
	logic [36:0]        bt_q;
	logic [53:0]        err_mag_q;
	logic               err_neg_q;
	logic signed [33:0] corr_q;
	logic [46:0]        rp_q;
	logic [32:0]        ratio_q;
	logic [19:0]        need_q;
	status_t            status_q;
	logic [13:0]        drain_q;
	logic [13:0]        to_read_q;

	seq_state_t state_q, state_d;
	logic       launch_q;
	logic       m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	ffrmc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	ffrmc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));

	// ---------------- combinational datapath ----------------
	logic               s_acc;
	logic               out_free;
	logic [13:0]        fill_in, fill_sat, tgt, fill_eff;
	logic               active, prime_go, compute, acq;
	loop_mode_t         mode_eff;
	logic [24:0]        alpha;
	logic signed [30:0] diff, d2;
	logic [29:0]        diff_mag, d2_mag;
	logic [29:0]        lpf_step;
	logic signed [42:0] qi_s, isum, isum_c;
	logic signed [49:0] qp_s, csum, csum_c;
	logic signed [34:0] dd, dd_c;
	logic [37:0]        at_sum;
	logic [40:0]        scale;
	logic [46:0]        rnd;
	logic [14:0]        cap;

	always_comb begin
		s_acc    = s_tvalid && s_tready;
		out_free = !m_tvalid_q || m_tready;
		fill_in  = s_tdata[26:13];
		fill_sat = (fill_in > DEPTH_CAP) ? DEPTH_CAP : fill_in;
		tgt      = (target_q == '0) ? 14'd1 : target_q;

		active   = (bs_q != '0) && (in_rate_q != '0) && (out_rate_q != '0) && cap_q &&
		           (bs_q <= max_block_q);
		fill_eff = pending_q ? 14'd0 : fill_q;
		mode_eff = pending_q ? MODE_PRIMING : mode_q;
		prime_go = (mode_eff == MODE_PRIMING) && (fill_eff >= tgt);
		compute  = active && ((mode_eff != MODE_PRIMING) || prime_go);
		acq      = (mode_q == MODE_ACQUIRING);

		alpha    = (bt_q > 37'(Q24_ONE)) ? Q24_ONE : bt_q[24:0];
		diff     = $signed({1'b0, fill_q, 16'h0000}) - $signed({1'b0, ff_q});
		diff_mag = diff[30] ? 30'(-diff) : diff[29:0];
		lpf_step = mul_rsp.product[53:24];
		d2       = $signed({1'b0, ff_q}) - $signed({1'b0, tgt, 16'h0000});
		d2_mag   = d2[30] ? 30'(-d2) : d2[29:0];

		qi_s   = err_neg_q ? -$signed({2'b00, div_rsp.quotient[40:0]})
		                   :  $signed({2'b00, div_rsp.quotient[40:0]});
		isum   = qi_s + $signed({{11{integ_q[31]}}, integ_q});
		isum_c = (isum > ILIM) ? ILIM : ((isum < -ILIM) ? -ILIM : isum);

		qp_s   = err_neg_q ? -$signed({2'b00, div_rsp.quotient[47:0]})
		                   :  $signed({2'b00, div_rsp.quotient[47:0]});
		csum   = qp_s + $signed({{18{integ_q[31]}}, integ_q});
		csum_c = (csum > CLIM) ? CLIM : ((csum < -CLIM) ? -CLIM : csum);

		dd     = $signed({corr_q[33], corr_q}) - $signed({prev_q[33], prev_q});
		dd_c   = (dd > SLIM) ? SLIM : ((dd < -SLIM) ? -SLIM : dd);
		at_sum = {6'b000000, at_q} + {1'b0, bt_q};

		scale  = 41'h100_0000_0000 + {{7{prev_q[33]}}, prev_q};
		rnd    = mul_rsp.product[46:0] + 47'd268435455;
		cap    = 15'({max_block_q, 1'b0}) + 15'(max_block_q) + 15'd32;
	end

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: if (s_acc) state_d = SQ_PRE;
			SQ_PRE:  state_d = compute ? SQ_BT : SQ_WB;
			SQ_BT:   if (div_rsp.done) state_d = SQ_LPF;
			SQ_LPF:  if (mul_rsp.done) state_d = SQ_ERR;
			SQ_ERR:  if (div_rsp.done) state_d = SQ_KI;
			SQ_KI:   if (div_rsp.done) state_d = SQ_KP;
			SQ_KP:   if (div_rsp.done) state_d = SQ_SLEW;
			SQ_SLEW: state_d = freeze_q ? SQ_RDIV : SQ_RMUL;
			SQ_RMUL: if (mul_rsp.done) state_d = SQ_RDIV;
			SQ_RDIV: if (div_rsp.done) state_d = SQ_NEED;
			SQ_NEED: if (mul_rsp.done) state_d = SQ_FIN;
			SQ_FIN:  state_d = SQ_WB;
			SQ_WB:   if (out_free) state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		s_tready         = (state_q == SQ_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = out_rate_q;
		mul_req.start    = 1'b0;
		mul_req.mcand    = '0;
		mul_req.mplier   = '0;
		case (state_q)
			SQ_BT: begin
				div_req.start    = launch_q;
				div_req.dividend = DIV_W'({bs_q, 24'h000000});
			end
			SQ_LPF: begin
				mul_req.start  = launch_q;
				mul_req.mcand  = MC_W'(diff_mag);
				mul_req.mplier = alpha;
			end
			SQ_ERR: begin
				div_req.start    = launch_q;
				div_req.dividend = DIV_W'({d2_mag, 24'h000000});
				div_req.divisor  = DIVR_W'(tgt);
			end
			SQ_KI: begin
				div_req.start    = launch_q;
				div_req.dividend = DIV_W'(err_mag_q);
				div_req.divisor  = acq ? KI_ACQ : KI_LOCK;
			end
			SQ_KP: begin
				div_req.start    = launch_q;
				div_req.dividend = DIV_W'(err_mag_q);
				div_req.divisor  = acq ? KP_ACQ : KP_LOCK;
			end
			SQ_RMUL: begin
				mul_req.start  = launch_q;
				mul_req.mcand  = MC_W'(scale);
				mul_req.mplier = MP_W'(in_rate_q);
			end
			SQ_RDIV: begin
				div_req.start    = launch_q;
				div_req.dividend = freeze_q ? DIV_W'({in_rate_q, 28'h0000000})
				                            : DIV_W'(rp_q);
			end
			SQ_NEED: begin
				mul_req.start  = launch_q;
				mul_req.mcand  = MC_W'(ratio_q);
				mul_req.mplier = MP_W'(bs_q);
			end
			default: ;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			launch_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
			in_rate_q   <= 18'd48000;
			out_rate_q  <= 18'd48000;
			target_q    <= 14'd1024;
			freeze_q    <= 1'b0;
			max_block_q <= 13'd512;
			mode_q      <= MODE_PRIMING;
			pending_q   <= 1'b1;
			ff_q        <= {14'd1024, 16'h0000};
			integ_q     <= '0;
			prev_q      <= '0;
			at_q        <= '0;
		end else begin
			state_q  <= state_d;
			launch_q <= (state_d != state_q);

			if (state_q == SQ_WB && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_idx)
					CFG_IN_RATE:   in_rate_q   <= cfg_data;
					CFG_OUT_RATE:  out_rate_q  <= cfg_data;
					CFG_TARGET:    target_q    <= cfg_data[13:0];
					CFG_FREEZE:    freeze_q    <= cfg_data[0];
					CFG_MAX_BLOCK: max_block_q <= cfg_data[12:0];
					default: ;
				endcase
			end

			if (s_acc) begin
				pending_q <= pending_q | s_tdata[27];
			end

			case (state_q)
				SQ_PRE: begin
					if (active && pending_q) begin
						pending_q <= 1'b0;
						mode_q    <= MODE_PRIMING;
						ff_q      <= {target_q, 16'h0000};
						integ_q   <= '0;
						prev_q    <= '0;
						at_q      <= '0;
					end
					if (active && prime_go) begin
						mode_q <= MODE_ACQUIRING;
						at_q   <= '0;
						ff_q   <= {fill_eff, 16'h0000};
					end
				end
				SQ_LPF: if (mul_rsp.done) begin
					ff_q <= diff[30] ? (ff_q - lpf_step) : (ff_q + lpf_step);
				end
				SQ_KI: if (div_rsp.done) begin
					integ_q <= isum_c[31:0];
				end
				SQ_SLEW: begin
					prev_q <= prev_q + dd_c[33:0];
					if (acq) begin
						at_q <= (at_sum[37:32] != '0) ? 32'hFFFFFFFF : at_sum[31:0];
					end
				end
				SQ_FIN: begin
					if (need_q > {5'b00000, cap}) begin
						if (acq && at_q > LOCK_TIME) mode_q <= MODE_LOCKED;
					end else if ({6'b000000, fill_q} < need_q) begin
						mode_q <= MODE_PRIMING;
					end else if (acq && at_q > LOCK_TIME) begin
						mode_q <= MODE_LOCKED;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		if (s_acc) begin
			bs_q   <= s_tdata[12:0];
			fill_q <= fill_sat;
			cap_q  <= s_tdata[28];
		end
		case (state_q)
			SQ_PRE: begin
				ratio_q   <= '0;
				to_read_q <= '0;
				drain_q   <= '0;
				status_q  <= active ? STAT_PRIMING : STAT_INACTIVE;
				if (active && pending_q) begin
					drain_q <= fill_q;
					fill_q  <= '0;
				end
			end
			SQ_BT: if (div_rsp.done) bt_q <= div_rsp.quotient[36:0];
			SQ_ERR: if (div_rsp.done) begin
				err_mag_q <= div_rsp.quotient[53:0];
				err_neg_q <= d2[30];
			end
			SQ_KP: if (div_rsp.done) corr_q <= csum_c[33:0];
			SQ_RMUL: if (mul_rsp.done) rp_q <= mul_rsp.product[58:12];
			SQ_RDIV: if (div_rsp.done) begin
				ratio_q <= (div_rsp.quotient[DIV_W-1:33] != '0) ? RATIO_MAX
				                                                : div_rsp.quotient[32:0];
			end
			SQ_NEED: if (mul_rsp.done) need_q <= {1'b0, rnd[46:28]} + MARGIN;
			SQ_FIN: begin
				if (need_q > {5'b00000, cap}) begin
					status_q <= STAT_OVERALLOC;
				end else if ({6'b000000, fill_q} < need_q) begin
					status_q <= STAT_UNDERRUN;
				end else begin
					status_q  <= STAT_RUNNING;
					to_read_q <= need_q[13:0];
				end
			end
			SQ_WB: if (out_free) begin
				m_tdata_q <= {4'h0, to_read_q, ratio_q, prev_q, drain_q, mode_q, status_q};
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

### hw/rtl/ffrmc_chk.sv
`default_nettype none
module ffrmc_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [ffrmc_pkg::S_DATA_W-1:0] s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ffrmc_pkg::M_DATA_W-1:0] m_tdata
);
	import ffrmc_pkg::*;

	logic [2:0] st;
	assign st = m_tdata[2:0];

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st <= STAT_OVERALLOC))
		else $error("status code out of range");

	a_read_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && st != STAT_RUNNING) |-> (m_tdata[99:86] == '0))
		else $error("samples to read while not running");

	a_no_ratio_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (st == STAT_INACTIVE || st == STAT_PRIMING)) |-> (m_tdata[85:53] == '0))
		else $error("ratio given before the loop ran");

	a_underrun_primes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && st == STAT_UNDERRUN) |-> (m_tdata[4:3] == MODE_PRIMING))
		else $error("underrun without return to priming");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in work");

endmodule

bind fifo_fill_rate_matching_controller ffrmc_chk u_ffrmc_chk (.*);
`default_nettype wire
